>>> src/pirl_pkg.sv
// ----------------------------------------------------------------------------
// pirl_pkg
// Shared types and constants for the positional insert/remove list.
// ----------------------------------------------------------------------------
package pirl_pkg;

	localparam int POS_W = 5;
	localparam int LEN_W = 5;
	localparam int VAL_W = 32;

	// request codes
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	// value returned on everything but an accepted remove
	localparam logic signed [VAL_W-1:0] REJECT_VALUE = 32'sd1;

	typedef struct packed {
		logic                    action;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
	} pirl_in_t;

	typedef struct packed {
		logic                    accepted;
		logic signed [VAL_W-1:0] removed_value;
		logic [LEN_W-1:0]        length;
	} pirl_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SHIFT,
		ST_PUT,
		ST_FINISH
	} pirl_state_t;

endpackage

>>> src/positional_insert_remove_list_top.sv
// Sequence: a rejected request goes from the execute state straight to the finish state. An accepted
// insert moves count-position entries at one entry per cycle, then writes its value (at the tail it
// only writes); an accepted remove reads its entry and moves the entries above it down by one.
// Throughput: one request at a time; in_ready rises with out_valid once the output register is
// free. Reset clears the length and control state;
// the entry store is not cleared (no clearing pass), entries are written before use.
// ----------------------------------------------------------------------------
// positional_insert_remove_list_top
// Ordered list of signed 32-bit values with insert and remove at a position.
// ----------------------------------------------------------------------------
module positional_insert_remove_list_top import pirl_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  pirl_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output pirl_out_t out_data
);

	// address width, count width, and a common width for position/count compares
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	// control state
	pirl_state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic          out_valid_q, out_valid_d;
	pirl_out_t     out_q, out_d;

	// request and walk registers
	pirl_in_t               req_q, req_d;
	logic                   ok_q, ok_d;
	logic [AW-1:0]          idx_q, idx_d;     // next entry to read
	logic [AW-1:0]          last_q, last_d;   // final entry to read
	logic [AW-1:0]          prev_q, prev_d;   // entry read in the last cycle
	logic                   more_q, more_d;   // reads still to issue
	logic                   pend_q, pend_d;   // read data arrives this cycle
	logic                   head_q, head_d;   // remove: next data is the removed entry
	logic signed [VAL_W-1:0] got_q, got_d;

	// RAM port
	logic                we;
	logic [AW-1:0]       waddr;
	logic [VAL_W-1:0]    wdata;
	logic                re;
	logic [AW-1:0]       raddr;
	logic [VAL_W-1:0]    rdata;

	// range checks
	logic [CMPW-1:0] pos_ext;
	logic [CMPW-1:0] cnt_ext;
	logic [AW-1:0]   pos_a;
	logic [CW-1:0]   cnt_m1;
	logic            is_ins;
	logic            ins_ok;
	logic            rem_ok;

	assign pos_ext = CMPW'(req_q.position);
	assign cnt_ext = CMPW'(count_q);
	assign pos_a   = pos_ext[AW-1:0];
	assign cnt_m1  = count_q - CW'(1);
	assign is_ins  = (req_q.action == ACT_INSERT);
	// insert fits at any position up to the length, unless the list is full
	assign ins_ok  = is_ins && (pos_ext <= cnt_ext) && (cnt_ext != CMPW'(DEPTH));
	// remove needs an existing entry
	assign rem_ok  = !is_ins && (pos_ext < cnt_ext);

	pirl_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_entries (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				priority if (!(ins_ok || rem_ok)) begin
					state_d = ST_FINISH;
				end else if (rem_ok) begin
					state_d = ST_SHIFT;
				end else if (pos_ext != cnt_ext) begin
					state_d = ST_SHIFT;
				end else begin
					state_d = ST_PUT;
				end
			end
			ST_SHIFT: begin
				// last read data is written back in the cycle more_q is low
				if (!more_q) begin
					state_d = is_ins ? ST_PUT : ST_FINISH;
				end
			end
			ST_PUT: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath and outputs
	always_comb begin
		req_d       = req_q;
		ok_d        = ok_q;
		idx_d       = idx_q;
		last_d      = last_q;
		prev_d      = prev_q;
		more_d      = more_q;
		pend_d      = 1'b0;
		head_d      = head_q;
		got_d       = got_q;
		count_d     = count_q;
		out_d       = out_q;
		out_valid_d = out_valid_q;
		we          = 1'b0;
		waddr       = pos_a;
		wdata       = req_q.value;
		re          = 1'b0;
		raddr       = idx_q;

		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					req_d = in_data;
				end
			end
			ST_EXEC: begin
				ok_d   = ins_ok || rem_ok;
				head_d = 1'b0;
				if (is_ins) begin
					// walk from the tail down to the insert point
					idx_d  = cnt_m1[AW-1:0];
					last_d = pos_a;
					more_d = ins_ok && (pos_ext != cnt_ext);
				end else begin
					// walk from the removed entry up to the tail
					idx_d  = pos_a;
					last_d = cnt_m1[AW-1:0];
					more_d = rem_ok;
					head_d = 1'b1;
				end
			end
			ST_SHIFT: begin
				if (more_q) begin
					re     = 1'b1;
					pend_d = 1'b1;
					prev_d = idx_q;
					if (idx_q == last_q) begin
						more_d = 1'b0;
					end else begin
						idx_d = is_ins ? idx_q - AW'(1) : idx_q + AW'(1);
					end
				end
				if (pend_q) begin
					wdata = rdata;
					if (is_ins) begin
						we    = 1'b1;
						waddr = prev_q + AW'(1);
					end else if (head_q) begin
						got_d  = rdata;
						head_d = 1'b0;
					end else begin
						we    = 1'b1;
						waddr = prev_q - AW'(1);
					end
				end
			end
			ST_PUT: begin
				we    = 1'b1;
				waddr = pos_a;
				wdata = req_q.value;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					if (ok_q) begin
						count_d = is_ins ? count_q + CW'(1) : count_q - CW'(1);
					end
					out_d.accepted      = ok_q;
					out_d.removed_value = (ok_q && !is_ins) ? got_q : REJECT_VALUE;
					out_d.length        = LEN_W'(CMPW'(count_d));
					out_valid_d         = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			more_q      <= 1'b0;
			pend_q      <= 1'b0;
			head_q      <= 1'b0;
			ok_q        <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
			more_q      <= more_d;
			pend_q      <= pend_d;
			head_q      <= head_d;
			ok_q        <= ok_d;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		req_q  <= req_d;
		idx_q  <= idx_d;
		last_q <= last_d;
		prev_q <= prev_d;
		got_q  <= got_d;
		out_q  <= out_d;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// the length never passes the capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("list length above capacity");

	// the length moves by at most one entry per request
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + CW'(1)) || (count_q + CW'(1) == $past(count_q))))
		else $error("length changed by more than one");

	// a new result is only loaded from the finish step
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
		else $error("result loaded outside finish step");

	// entry store is never written while waiting for a request
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !we)
		else $error("entry write while idle");
`endif

endmodule

>>> src/pirl_ram.sv
// ----------------------------------------------------------------------------
// pirl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pirl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> dv/positional_insert_remove_list_checker.sv
// ----------------------------------------------------------------------------
// positional_insert_remove_list_checker
// Watches both channels of the list block, keeps a shadow copy of the list,
// predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module positional_insert_remove_list_checker import pirl_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  pirl_in_t         in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  pirl_out_t        out_data,
	output int               fail_count,
	output int               pending,
	output logic [LEN_W-1:0] list_len
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [VAL_W-1:0] shadow_list [DEPTH];
	int                      shadow_cnt = 0;
	pirl_out_t               awaited_results [$];
	int                      err_cnt = 0;

	task automatic report_mismatch(input string msg);
		$display("%0t ns list check: %s", $time, msg);
		err_cnt++;
	endtask

	// Apply one request to the shadow list and build the result it must give.
	task automatic apply_request(input pirl_in_t req, output pirl_out_t res);
		int i;
		int pos;
		pos               = req.position;
		res.accepted      = 1'b0;
		res.removed_value = REJECT_VALUE;
		if (req.action == ACT_INSERT) begin
			if (pos <= shadow_cnt && shadow_cnt < DEPTH) begin
				for (i = shadow_cnt; i > pos; i--)
					shadow_list[i] = shadow_list[i-1];
				shadow_list[pos] = req.value;
				shadow_cnt++;
				res.accepted = 1'b1;
			end
		end else begin
			if (pos < shadow_cnt) begin
				res.removed_value = shadow_list[pos];
				for (i = pos; i + 1 < shadow_cnt; i++)
					shadow_list[i] = shadow_list[i+1];
				shadow_cnt--;
				res.accepted = 1'b1;
			end
		end
		res.length = shadow_cnt[LEN_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pirl_out_t want;
		pirl_out_t fresh;
		if (!arst_n) begin
			shadow_cnt = 0;
			awaited_results.delete();
			fail_count <= 0;
			pending    <= 0;
			list_len   <= '0;
		end else begin
			// a result never leaves in the cycle of its own request, so the
			// check comes before the new request is queued
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result transfer with no request waiting");
				end else begin
					want = awaited_results.pop_front();
					if (out_data.accepted !== want.accepted)
						report_mismatch($sformatf("accepted %0b, want %0b",
							out_data.accepted, want.accepted));
					if (out_data.removed_value !== want.removed_value)
						report_mismatch($sformatf("removed_value %0d, want %0d",
							out_data.removed_value, want.removed_value));
					if (out_data.length !== want.length)
						report_mismatch($sformatf("length %0d, want %0d",
							out_data.length, want.length));
				end
			end
			if (in_valid && in_ready) begin
				apply_request(in_data, fresh);
				awaited_results.push_back(fresh);
			end
			fail_count <= err_cnt;
			pending    <= awaited_results.size();
			list_len   <= shadow_cnt[LEN_W-1:0];
		end
	end

endmodule

>>> dv/tb_positional_insert_remove_list_top.sv
// ----------------------------------------------------------------------------
// tb_positional_insert_remove_list_top
// Drives insert/remove requests into the list block with random gaps and
// backpressure; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_positional_insert_remove_list_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pirl_pkg::*;

	localparam int DEPTH        = 16;
	localparam int CLK_HALF     = 6;
	localparam int RUN_ITEMS    = 2000;
	localparam int PAUSE_AT     = 1000;      // sender waits for a drained block here
	localparam int HOLD_START   = 4000;      // receiver hold-off window, in cycles
	localparam int HOLD_LEN     = 500;
	localparam int QUIET_START  = 10000;     // no idling on either side in here
	localparam int QUIET_END    = 14000;
	localparam int DRAIN_CYCLES = DEPTH + 8; // longest walk plus margin
	localparam int CYCLE_LIMIT  = 600000;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	pirl_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	pirl_out_t out_data;

	int               fail_count;
	int               pending;
	logic [LEN_W-1:0] list_len;
	int               cycle_cnt;

	always #CLK_HALF clk = ~clk;

	positional_insert_remove_list_top #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	positional_insert_remove_list_checker #(
		.DEPTH(DEPTH)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.fail_count(fail_count),
		.pending   (pending),
		.list_len  (list_len)
	);

	// Cycle counter: paces the idle windows and ends a run that hangs.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_cnt <= 0;
		end else begin
			cycle_cnt <= cycle_cnt + 1;
			if (cycle_cnt >= CYCLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	function automatic bit quiet_window();
		return cycle_cnt >= QUIET_START && cycle_cnt < QUIET_END;
	endfunction

	function automatic pirl_in_t make_req(logic act, int pos, logic [VAL_W-1:0] val);
		pirl_in_t req;
		req.action   = act;
		req.position = pos[POS_W-1:0];
		req.value    = val;
		return req;
	endfunction

	// Random request. Most are well formed against the current list length
	// (which lags by one transfer, so a few still miss); the bias flips
	// every 150 requests so the list swings between empty and full.
	// About one in twelve is noise over the whole position field.
	function automatic pirl_in_t random_request(int idx, int len);
		logic             act;
		int               pos;
		logic [VAL_W-1:0] val;
		bit               fill_bias;
		fill_bias = ((idx / 150) % 2) == 0;
		if ($urandom_range(99) < 8) begin
			act = $urandom_range(1) ? ACT_REMOVE : ACT_INSERT;
			pos = $urandom_range(31);
		end else begin
			act = ($urandom_range(99) < (fill_bias ? 70 : 30)) ? ACT_INSERT : ACT_REMOVE;
			if (act == ACT_INSERT)
				pos = $urandom_range(len);
			else
				pos = (len == 0) ? 0 : $urandom_range(len - 1);
		end
		// extremes now and then, otherwise any 32-bit pattern
		case ($urandom_range(9))
			0:       val = 32'h8000_0000;
			1:       val = 32'h7fff_ffff;
			2:       val = $urandom_range(1) ? '1 : '0;
			default: val = $urandom;
		endcase
		return make_req(act, pos, val);
	endfunction

	// One transfer on the request side. Valid only drops when a gap is
	// taken; back-to-back requests keep it high across the transfer edge.
	task automatic send_request(input pirl_in_t req);
		int gap;
		if (!quiet_window() && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Wait until the checker has nothing left outstanding.
	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Result side: random stalls, one long hold-off that lets the block
	// fill up and stall its input, and a stretch of constant ready.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (cycle_cnt == HOLD_START)
				hold_left = HOLD_LEN;
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (quiet_window()) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 18);
			end
		end
	end

	initial begin : stimulus
		int k;
		int n;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// remove from an empty list, insert past the end of an empty list
		send_request(make_req(ACT_REMOVE, 0, 32'h0));
		send_request(make_req(ACT_INSERT, 1, 32'h1234_5678));
		// insert then remove the only entry: list goes back to empty
		send_request(make_req(ACT_INSERT, 0, 32'h7fff_ffff));
		send_request(make_req(ACT_REMOVE, 0, 32'hffff_ffff));
		// head, tail and middle inserts with extreme values
		send_request(make_req(ACT_INSERT, 0, 32'h7fff_ffff));
		send_request(make_req(ACT_INSERT, 0, 32'h8000_0000));
		send_request(make_req(ACT_INSERT, 2, 32'h0000_0000));
		send_request(make_req(ACT_INSERT, 1, 32'hffff_ffff));
		// insert far past the end, remove at exactly the length
		send_request(make_req(ACT_INSERT, 31, 32'h5555_5555));
		send_request(make_req(ACT_REMOVE, 4, 32'h0));
		// remove from the middle
		send_request(make_req(ACT_REMOVE, 1, 32'haaaa_aaaa));
		// fill up to DEPTH, scattering the insert positions
		for (k = 0; k < 13; k++)
			send_request(make_req(ACT_INSERT, (k * 7) % (k + 4), 32'ha5a5_0000 + k));
		// insert into a full list, then remove the tail and the head
		send_request(make_req(ACT_INSERT, 0, 32'h0bad_0bad));
		send_request(make_req(ACT_REMOVE, 15, 32'h0));
		send_request(make_req(ACT_REMOVE, 0, 32'h0));

		// --- random part ---
		for (n = 0; n < RUN_ITEMS; n++) begin
			if (n == PAUSE_AT) begin
				// sender stops until every expected result is out
				in_valid <= 1'b0;
				wait_drained();
			end
			send_request(random_request(n, list_len));
		end

		in_valid <= 1'b0;
		wait_drained();
		// let a stray late result show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> sim.f
src/pirl_pkg.sv
src/pirl_ram.sv
src/positional_insert_remove_list_top.sv
dv/positional_insert_remove_list_checker.sv
dv/tb_positional_insert_remove_list_top.sv
